/* rtl/core/metronome_click_generator_defines.svh */
// assertion macros for the metronome click generator
// used at the end of the top level, no other dependencies
`ifndef METRONOME_CLICK_GENERATOR_DEFINES_SVH
`define METRONOME_CLICK_GENERATOR_DEFINES_SVH

// combinational implication, checked every edge outside reset
`define MCG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// implication checked on the following cycle
`define MCG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mcg_pkg.sv */
// constants, types and constant tables of the metronome click generator
// no dependencies; used by metronome_click_generator
`timescale 1ns / 1ps

package mcg_pkg;

    localparam int MAX_VOICES   = 4;
    localparam int VOICE_W      = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CLICK_LENGTH = 2048;
    localparam int AGE_W        = $clog2(CLICK_LENGTH);
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);
    localparam int SMP_W        = 15;
    localparam int ENV_W        = 17;
    localparam int MIX_W        = 16 + VOICE_W + 1;
    localparam int TICKS_W      = 9;
    localparam int DIV_W        = 24;
    localparam int DIV_CNT_W    = $clog2(DIV_W + 1);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ENV_DEN     = 64'(3 * (CLICK_LENGTH - 1));
    localparam logic [63:0] ENV_FALL    = 64'(7 * (CLICK_LENGTH - 1));

    // register indexes of the configuration port
    localparam logic [2:0] CFG_BAR_LENGTH   = 3'd0;
    localparam logic [2:0] CFG_BEATS        = 3'd1;
    localparam logic [2:0] CFG_TICKS        = 3'd2;
    localparam logic [2:0] CFG_ACCENT_STEP  = 3'd3;
    localparam logic [2:0] CFG_BEAT_STEP    = 3'd4;
    localparam logic [2:0] CFG_SUB_STEP     = 3'd5;

    typedef enum logic [1:0] {
        KIND_ACCENT = 2'd0,
        KIND_BEAT   = 2'd1,
        KIND_SUB    = 2'd2
    } t_kind;

    typedef struct packed {
        logic [AGE_W-1:0] age;
        logic [31:0]      phase;
        t_kind            pitch;
    } t_voice;

    typedef logic [SINE_ENTRIES:0][SMP_W-1:0]   t_sine_tab;
    typedef logic [CLICK_LENGTH-1:0][ENV_W-1:0] t_env_tab;

    // quarter-wave table, taylor series in q2.30
    function automatic t_sine_tab build_sine();
        t_sine_tab   tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        for (int k = 0; k <= SINE_ENTRIES; k++) begin
            x    = 64'(k) * HALF_PI_Q30 / 64'(SINE_ENTRIES);
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= 8; n++) begin
                term = (term * x2) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    sum = (sum > term) ? sum - term : 64'd0;
                end else begin
                    sum = sum + term;
                end
            end
            v = (sum * 64'd32767 + 64'd536870912) >> 30;
            tab[k] = (v > 64'd32767) ? SMP_W'(32767) : v[SMP_W-1:0];
        end
        return tab;
    endfunction

    function automatic logic [63:0] smooth(input logic [63:0] num);
        logic [63:0] t;
        logic [63:0] t2;
        t = num * 64'd65536 / ENV_DEN;
        if (t > 64'd65536) begin
            t = 64'd65536;
        end
        t2 = (t * t) >> 16;
        return (t2 * (64'd196608 - 64'd2 * t)) >> 16;
    endfunction

    // fade-in / fade-out envelope, 65536 is full scale
    function automatic t_env_tab build_env();
        t_env_tab    tab;
        logic [63:0] a;
        logic [63:0] e;
        for (int j = 0; j < CLICK_LENGTH; j++) begin
            a = 64'd10 * 64'(j);
            e = smooth(a) - ((a > ENV_FALL) ? smooth(a - ENV_FALL) : 64'd0);
            tab[j] = e[ENV_W-1:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine();
    localparam t_env_tab  ENV_TAB  = build_env();

endpackage

/* rtl/core/metronome_click_generator.sv */
// metronome click generator: bar/tick sequencer, voice memory and mixer
// depends on mcg_pkg and metronome_click_generator_defines.svh
`timescale 1ns / 1ps

// Each accepted transaction is one audio sample and yields one mixed sample with a
// click-start flag and kind. Voice state (age, phase, pitch) lives in a small
// synchronous memory and is served one voice at a time by a single multiplier.
// A sample runs one pass of the shared 24-step divider, then visits every voice; an
// active voice goes through the read, lookup, multiply and accumulate states. Each click
// started on the sample adds two more passes of the divider, plus a scan of all voices
// when a busy voice has to be stolen. The divider and the one-voice-at-a-time memory
// access set the time a sample takes. A result waits in the output register while the next sample is accepted.
module metronome_click_generator (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_restart,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic signed [15:0]     o_mixed_sample,
    output logic                   o_tick_start,
    output logic [1:0]             o_tick_kind,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [2:0]             i_cfg_index,
    input  logic [31:0]            i_cfg_data
);
    import mcg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV_LEN, S_TICK_CHK, S_DIV_KIND, S_PICK, S_SCAN,
        S_DIV_SUM, S_VRD, S_VLK, S_VMUL, S_VACC, S_FIN
    } t_state;

    t_state r_state;

    // configuration
    logic [23:0] r_bar_length;
    logic [4:0]  r_beats;
    logic [4:0]  r_ticks_per_beat;
    logic [31:0] r_accent_step;
    logic [31:0] r_beat_step;
    logic [31:0] r_sub_step;

    // bar state
    logic [23:0]        r_bar_pos;
    logic [TICKS_W-1:0] r_tick;
    logic [23:0]        r_next_pos;
    logic [7:0]         r_spacing;
    logic [23:0]        r_len_q;
    logic [TICKS_W-1:0] r_len_r;

    // divider
    logic                 r_dv_busy;
    logic [DIV_CNT_W-1:0] r_dv_cnt;
    logic [DIV_W-1:0]     r_dv_q;
    logic [TICKS_W-1:0]   r_dv_r;
    logic [TICKS_W-1:0]   r_dv_d;

    // voices
    logic [MAX_VOICES-1:0] r_busy;
    t_voice                r_mem [MAX_VOICES];
    t_voice                r_rd;
    logic [VOICE_W:0]      r_vcnt;
    logic [VOICE_W:0]      r_scan;
    logic [VOICE_W-1:0]    r_pick;
    logic [AGE_W-1:0]      r_best_age;
    t_kind                 r_kind;
    logic                  r_started;
    t_kind                 r_first;

    // mixer
    logic [SMP_W-1:0]        r_sine_mag;
    logic [ENV_W-1:0]        r_env;
    logic                    r_neg;
    logic [15:0]             r_prod;
    logic signed [MIX_W-1:0] r_mix;

    logic               r_out_valid;
    logic signed [15:0] r_out_sample;
    logic               r_out_start;
    t_kind              r_out_kind;

    // combinational
    logic [23:0]        len;
    logic [4:0]         sub_c;
    logic [4:0]         beats_c;
    logic [TICKS_W-1:0] ticks;
    logic               tick_due;
    logic               in_acc;
    logic               free_any;
    logic [VOICE_W-1:0] free_idx;
    logic               scan_better;
    logic [VOICE_W-1:0] scan_pick;
    logic [VOICE_W-1:0] vidx;
    logic [9:0]         sum_val;
    logic [9:0]         dv_sh;
    logic               dv_ge;
    logic               dv_start;
    logic [DIV_W-1:0]   dv_num;
    logic [TICKS_W-1:0] dv_den;
    logic               mem_re;
    logic [VOICE_W-1:0] mem_raddr;
    logic               mem_we;
    logic [VOICE_W-1:0] mem_waddr;
    t_voice             mem_wdata;
    logic [31:0]        step_c;
    logic [SINE_IDX_W:0] sine_addr;
    logic [SINE_IDX_W-1:0] sine_idx;
    t_kind              kind_c;
    logic [31:0]        prod_full;
    logic signed [MIX_W-1:0] mix_sat_hi;
    logic signed [MIX_W-1:0] mix_sat_lo;
    logic signed [15:0] mix_out;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_mixed_sample = r_out_sample;
    assign o_tick_start   = r_out_start;
    assign o_tick_kind    = r_out_kind;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign len     = (r_bar_length == '0) ? 24'd1 : r_bar_length;
    assign sub_c   = (r_ticks_per_beat == '0) ? 5'd1 :
                     (r_ticks_per_beat > 5'd16) ? 5'd16 : r_ticks_per_beat;
    assign beats_c = (r_beats == '0) ? 5'd1 : (r_beats > 5'd16) ? 5'd16 : r_beats;
    assign ticks   = TICKS_W'(beats_c) * TICKS_W'(sub_c);
    assign tick_due = (r_tick < ticks) && (r_next_pos <= r_bar_pos);
    assign vidx    = r_vcnt[VOICE_W-1:0];
    assign sum_val = {2'b00, r_spacing} + {1'b0, r_len_r};

    assign dv_sh = {r_dv_r, r_dv_q[DIV_W-1]};
    assign dv_ge = (dv_sh >= {1'b0, r_dv_d});

    assign kind_c = (r_tick == '0) ? KIND_ACCENT :
                    (r_dv_r == '0) ? KIND_BEAT : KIND_SUB;

    assign step_c = (r_rd.pitch == KIND_ACCENT) ? r_accent_step :
                    (r_rd.pitch == KIND_BEAT)   ? r_beat_step : r_sub_step;
    assign sine_idx  = r_rd.phase[29 -: SINE_IDX_W];
    assign sine_addr = r_rd.phase[30] ? ((SINE_IDX_W+1)'(SINE_ENTRIES) - {1'b0, sine_idx})
                                      : {1'b0, sine_idx};
    assign prod_full = 32'(r_env) * 32'(r_sine_mag);

    assign mix_sat_hi = MIX_W'(32767);
    assign mix_sat_lo = -MIX_W'(32768);
    assign mix_out = (r_mix > mix_sat_hi) ? 16'sd32767 :
                     (r_mix < mix_sat_lo) ? -16'sd32768 : r_mix[15:0];

    assign scan_better = (r_scan == (VOICE_W+1)'(1)) || (r_rd.age > r_best_age);
    assign scan_pick   = scan_better ? VOICE_W'(r_scan - (VOICE_W+1)'(1)) : r_pick;

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int v = MAX_VOICES - 1; v >= 0; v--) begin
            if (!r_busy[v]) begin
                free_any = 1'b1;
                free_idx = VOICE_W'(v);
            end
        end
    end

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = vidx;
        mem_we    = 1'b0;
        mem_waddr = vidx;
        mem_wdata = '{age: '0, phase: '0, pitch: r_kind};
        dv_start  = 1'b0;
        dv_num    = DIV_W'(sum_val);
        dv_den    = ticks;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    dv_start = 1'b1;
                    dv_num   = len;
                end
            end
            S_TICK_CHK: begin
                if (tick_due) begin
                    dv_start = 1'b1;
                    dv_num   = DIV_W'(r_tick);
                    dv_den   = TICKS_W'(sub_c);
                end
            end
            S_PICK: begin
                if (free_any) begin
                    mem_we    = 1'b1;
                    mem_waddr = free_idx;
                    dv_start  = 1'b1;
                end
            end
            S_SCAN: begin
                if (r_scan < (VOICE_W+1)'(MAX_VOICES)) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_scan[VOICE_W-1:0];
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = scan_pick;
                    dv_start  = 1'b1;
                end
            end
            S_VRD: begin
                if (r_vcnt < (VOICE_W+1)'(MAX_VOICES) && r_busy[vidx]) begin
                    mem_re = 1'b1;
                end
            end
            S_VLK: begin
                mem_we    = 1'b1;
                mem_wdata = '{age: r_rd.age + AGE_W'(1), phase: r_rd.phase + step_c,
                              pitch: r_rd.pitch};
            end
            default: begin
            end
        endcase
    end

    // voice memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_raddr];
        end
    end

    // shared restoring divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
            r_dv_cnt  <= '0;
        end else if (dv_start) begin
            r_dv_busy <= 1'b1;
            r_dv_cnt  <= DIV_CNT_W'(DIV_W);
            r_dv_q    <= dv_num;
            r_dv_r    <= '0;
            r_dv_d    <= dv_den;
        end else if (r_dv_busy) begin
            r_dv_r   <= dv_ge ? TICKS_W'(dv_sh - {1'b0, r_dv_d}) : dv_sh[TICKS_W-1:0];
            r_dv_q   <= {r_dv_q[DIV_W-2:0], dv_ge};
            r_dv_cnt <= r_dv_cnt - DIV_CNT_W'(1);
            if (r_dv_cnt == DIV_CNT_W'(1)) begin
                r_dv_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_bar_length     <= 24'd96000;
            r_beats          <= 5'd4;
            r_ticks_per_beat <= 5'd1;
            r_accent_step    <= 32'd93639230;
            r_beat_step      <= 32'd46819615;
            r_sub_step       <= 32'd23409850;
            r_bar_pos        <= '0;
            r_tick           <= '0;
            r_next_pos       <= '0;
            r_spacing        <= '0;
            r_busy           <= '0;
            r_out_valid      <= 1'b0;
            r_started        <= 1'b0;
            r_vcnt           <= '0;
            r_scan           <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_BAR_LENGTH:  r_bar_length     <= i_cfg_data[23:0];
                    CFG_BEATS:       r_beats          <= i_cfg_data[4:0];
                    CFG_TICKS:       r_ticks_per_beat <= i_cfg_data[4:0];
                    CFG_ACCENT_STEP: r_accent_step    <= i_cfg_data;
                    CFG_BEAT_STEP:   r_beat_step      <= i_cfg_data;
                    CFG_SUB_STEP:    r_sub_step       <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (r_out_valid && !i_out_stall && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_started <= 1'b0;
                        r_first   <= KIND_ACCENT;
                        r_mix     <= '0;
                        if (i_restart) begin
                            r_bar_pos  <= '0;
                            r_tick     <= '0;
                            r_next_pos <= '0;
                            r_spacing  <= '0;
                            r_busy     <= '0;
                        end
                        r_state <= S_DIV_LEN;
                    end
                end
                S_DIV_LEN: begin
                    if (!r_dv_busy) begin
                        r_len_q <= r_dv_q;
                        r_len_r <= r_dv_r;
                        r_state <= S_TICK_CHK;
                    end
                end
                S_TICK_CHK: begin
                    if (tick_due) begin
                        r_state <= S_DIV_KIND;
                    end else begin
                        r_vcnt  <= '0;
                        r_state <= S_VRD;
                    end
                end
                S_DIV_KIND: begin
                    if (!r_dv_busy) begin
                        r_kind <= kind_c;
                        if (!r_started) begin
                            r_started <= 1'b1;
                            r_first   <= kind_c;
                        end
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (free_any) begin
                        r_busy[free_idx] <= 1'b1;
                        r_state          <= S_DIV_SUM;
                    end else begin
                        r_scan  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // all voices busy: steal the oldest, lowest index on a tie
                    if (r_scan != '0) begin
                        r_pick <= scan_pick;
                        if (scan_better) begin
                            r_best_age <= r_rd.age;
                        end
                    end
                    if (r_scan == (VOICE_W+1)'(MAX_VOICES)) begin
                        r_busy[scan_pick] <= 1'b1;
                        r_state           <= S_DIV_SUM;
                    end else begin
                        r_scan <= r_scan + (VOICE_W+1)'(1);
                    end
                end
                S_DIV_SUM: begin
                    if (!r_dv_busy) begin
                        r_tick     <= r_tick + TICKS_W'(1);
                        r_next_pos <= r_next_pos + r_len_q + r_dv_q;
                        r_spacing  <= r_dv_r[7:0];
                        r_state    <= S_TICK_CHK;
                    end
                end
                S_VRD: begin
                    if (r_vcnt == (VOICE_W+1)'(MAX_VOICES)) begin
                        r_state <= S_FIN;
                    end else if (r_busy[vidx]) begin
                        r_state <= S_VLK;
                    end else begin
                        r_vcnt <= r_vcnt + (VOICE_W+1)'(1);
                    end
                end
                S_VLK: begin
                    r_sine_mag <= SINE_TAB[sine_addr];
                    r_env      <= ENV_TAB[r_rd.age];
                    r_neg      <= r_rd.phase[31];
                    if (r_rd.age == AGE_W'(CLICK_LENGTH - 1)) begin
                        r_busy[vidx] <= 1'b0;
                    end
                    r_state <= S_VMUL;
                end
                S_VMUL: begin
                    r_prod  <= prod_full[31:16];
                    r_state <= S_VACC;
                end
                S_VACC: begin
                    if (r_neg) begin
                        r_mix <= r_mix - MIX_W'(r_prod);
                    end else begin
                        r_mix <= r_mix + MIX_W'(r_prod);
                    end
                    r_vcnt  <= r_vcnt + (VOICE_W+1)'(1);
                    r_state <= S_VRD;
                end
                S_FIN: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= mix_out;
                        r_out_start  <= r_started;
                        r_out_kind   <= r_first;
                        if ({1'b0, r_bar_pos} + 25'd1 >= {1'b0, len}) begin
                            r_bar_pos  <= '0;
                            r_tick     <= '0;
                            r_next_pos <= '0;
                            r_spacing  <= '0;
                        end else begin
                            r_bar_pos <= r_bar_pos + 24'd1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "metronome_click_generator_defines.svh"

    `MCG_ASSERT_IMPL(a_div_only_waiting, i_clk, i_rst_n, r_dv_busy, (r_state == S_DIV_LEN || r_state == S_DIV_KIND || r_state == S_DIV_SUM), "divider running outside a wait state")
    `MCG_ASSERT_IMPL(a_no_tick_kind, i_clk, i_rst_n, o_out_valid && !o_tick_start, o_tick_kind == KIND_ACCENT, "tick kind set without a click start")
    `MCG_ASSERT_IMPL(a_voice_mag, i_clk, i_rst_n, r_state == S_VACC, !r_prod[15], "voice magnitude beyond 15 bits")
    `MCG_ASSERT_NEXT(a_start_marks_busy, i_clk, i_rst_n, r_state == S_PICK && free_any, r_busy[$past(free_idx)], "started voice not marked busy")

endmodule
